// ===== rtl/trapezoid_profile_calc_defines.svh =====
// assertion macros shared by the trapezoid profile rtl
`ifndef TRAPEZOID_PROFILE_CALC_DEFINES_SVH
`define TRAPEZOID_PROFILE_CALC_DEFINES_SVH

// same-cycle implication, checked on clk with reset masking
`define TPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with a fixed cycle delay
`define TPC_ASSERT_DLY(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// ===== rtl/tpc_pkg.sv =====
// shared constants, types and helpers of the trapezoid profile calculator
package tpc_pkg;

    localparam int RATE_W    = 20;
    localparam int FACTOR_W  = 17;
    localparam int ACCEL_W   = 24;
    localparam int COUNT_W   = 24;
    localparam int MINR_W    = 16;
    localparam int OUT_W     = 32;
    localparam int NUM_W     = 52;
    localparam int DEN_W     = 26;
    localparam int WIDE_W    = 54;

    localparam logic [RATE_W-1:0] RATE_MAX       = 20'hFFFFF;
    localparam logic [MINR_W-1:0] MIN_RATE_RESET = 16'd120;

    typedef struct packed {
        logic                neg_acc;
        logic                neg_dec;
        logic                neg_ac2;
        logic                a_zero;
        logic [COUNT_W-1:0]  count;
        logic [RATE_W-1:0]   ir;
        logic [RATE_W-1:0]   fr;
        logic                busy;
    } side_t;

    // ceiling of product over 2^16, saturated, raised to the minimum rate
    function automatic logic [RATE_W-1:0] rate_clamp(input logic [36:0] prod,
                                                     input logic [MINR_W-1:0] minr);
        logic [37:0]       sum;
        logic [21:0]       q;
        logic [RATE_W-1:0] r;
        sum = {1'b0, prod} + 38'd65535;
        q   = sum[37:16];
        r   = (q > {2'b00, RATE_MAX}) ? RATE_MAX : q[RATE_W-1:0];
        if (r < {4'b0000, minr})
        begin
            r = {4'b0000, minr};
        end
        return r;
    endfunction

    // saturate to the signed 32-bit range
    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if ((&v[WIDE_W-1:OUT_W-1]) || !(|v[WIDE_W-1:OUT_W-1]))
        begin
            r = v[OUT_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/tpc_div.sv =====
// pipelined restoring unsigned divider, one quotient bit per stage
module tpc_div #(
    parameter int NUM_W = tpc_pkg::NUM_W,
    parameter int DEN_W = tpc_pkg::DEN_W
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic [NUM_W-1:0] quot
);

    logic [DEN_W-1:0] rem_reg [NUM_W-1];
    logic [DEN_W-1:0] den_reg [NUM_W-1];
    logic [NUM_W-1:0] nq_reg  [NUM_W];

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign den_in = denom;
            assign nq_in  = numer;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign nq_in  = nq_reg[s-1];
        end

        // shift in the next numerator bit and try a subtract
        always_comb
        begin
            trial = {rem_in, nq_in[NUM_W-1]};
            diff  = trial - {1'b0, den_in};
            ge    = (trial >= {1'b0, den_in});
        end

        always_ff @(posedge clk)
        begin
            nq_reg[s] <= {nq_in[NUM_W-2:0], ge};
        end

        if (s < NUM_W - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                den_reg[s] <= den_in;
            end
        end
    end

    assign quot = nq_reg[NUM_W-1];

endmodule

// ===== rtl/trapezoid_profile_calc.sv =====
// trapezoid velocity profile calculator, top level
// results pass from the start transfer through the front stages, the dividers and the back stages to the done strobe
// throughput: one segment per cycle, fixed by the 52-stage divider pipelines
// the receiver cannot stall, so busy stays low and the pipeline never holds
// reset clears every valid bit and sets min_rate_reg back to 120
`include "trapezoid_profile_calc_defines.svh"

module trapezoid_profile_calc (
    input  logic                                clk,
    input  logic                                rst_n,
    // segment transfer
    input  logic                                start,
    output logic                                busy,
    input  logic [tpc_pkg::RATE_W-1:0]          cruise_rate,
    input  logic [tpc_pkg::FACTOR_W-1:0]        entry_scale,
    input  logic [tpc_pkg::FACTOR_W-1:0]        exit_scale,
    input  logic [tpc_pkg::ACCEL_W-1:0]         accel_rate,
    input  logic [tpc_pkg::COUNT_W-1:0]         step_count,
    input  logic                                busy_req,
    // minimum rate register
    input  logic                                cfg_we,
    input  logic [tpc_pkg::MINR_W-1:0]          cfg_wdata,
    // result transfer
    output logic                                done,
    output logic signed [tpc_pkg::OUT_W-1:0]    accel_until,
    output logic signed [tpc_pkg::OUT_W-1:0]    decel_after,
    output logic [tpc_pkg::RATE_W-1:0]          start_rate,
    output logic [tpc_pkg::RATE_W-1:0]          end_rate,
    output logic                                applied
);

    localparam int RW  = tpc_pkg::RATE_W;
    localparam int AW  = tpc_pkg::ACCEL_W;
    localparam int CW  = tpc_pkg::COUNT_W;
    localparam int NW  = tpc_pkg::NUM_W;
    localparam int DW  = tpc_pkg::DEN_W;
    localparam int WW  = tpc_pkg::WIDE_W;
    localparam int LAT = 5 + NW + 2;

    // config register
    logic [tpc_pkg::MINR_W-1:0] min_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rate_reg <= tpc_pkg::MIN_RATE_RESET;
        end
        else if (cfg_we)
        begin
            min_rate_reg <= cfg_wdata;
        end
    end

    // no backpressure anywhere
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // valid bits for the front, divider and back stages
    logic [4:0]    fv_reg;
    logic [NW-1:0] dv_reg;
    logic [1:0]    bv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
            dv_reg <= '0;
            bv_reg <= '0;
        end
        else
        begin
            fv_reg <= {fv_reg[3:0], accept};
            dv_reg <= {dv_reg[NW-2:0], fv_reg[4]};
            bv_reg <= {bv_reg[0], dv_reg[NW-1]};
        end
    end

    // stage 1: rate products
    logic [36:0]   pe_s1_reg, px_s1_reg;
    logic [RW-1:0] nom_s1_reg;
    logic [AW-1:0] a_s1_reg;
    logic [CW-1:0] cnt_s1_reg;
    logic          busy_s1_reg;

    always_ff @(posedge clk)
    begin
        pe_s1_reg   <= {17'd0, cruise_rate} * {20'd0, entry_scale};
        px_s1_reg   <= {17'd0, cruise_rate} * {20'd0, exit_scale};
        nom_s1_reg  <= cruise_rate;
        a_s1_reg    <= accel_rate;
        cnt_s1_reg  <= step_count;
        busy_s1_reg <= busy_req;
    end

    // stage 2: round up, saturate, minimum clamp
    logic [RW-1:0] ir_s2_reg, fr_s2_reg, nom_s2_reg;
    logic [AW-1:0] a_s2_reg;
    logic [CW-1:0] cnt_s2_reg;
    logic          busy_s2_reg;

    always_ff @(posedge clk)
    begin
        ir_s2_reg   <= tpc_pkg::rate_clamp(pe_s1_reg, min_rate_reg);
        fr_s2_reg   <= tpc_pkg::rate_clamp(px_s1_reg, min_rate_reg);
        nom_s2_reg  <= nom_s1_reg;
        a_s2_reg    <= a_s1_reg;
        cnt_s2_reg  <= cnt_s1_reg;
        busy_s2_reg <= busy_s1_reg;
    end

    // stage 3: squares and 2a*count
    logic [39:0]   n2_s3_reg, i2_s3_reg, f2_s3_reg;
    logic [48:0]   tac_s3_reg;
    logic [RW-1:0] ir_s3_reg, fr_s3_reg;
    logic [AW-1:0] a_s3_reg;
    logic [CW-1:0] cnt_s3_reg;
    logic          busy_s3_reg;

    always_ff @(posedge clk)
    begin
        n2_s3_reg   <= {20'd0, nom_s2_reg} * {20'd0, nom_s2_reg};
        i2_s3_reg   <= {20'd0, ir_s2_reg} * {20'd0, ir_s2_reg};
        f2_s3_reg   <= {20'd0, fr_s2_reg} * {20'd0, fr_s2_reg};
        tac_s3_reg  <= {24'd0, a_s2_reg, 1'b0} * {25'd0, cnt_s2_reg};
        ir_s3_reg   <= ir_s2_reg;
        fr_s3_reg   <= fr_s2_reg;
        a_s3_reg    <= a_s2_reg;
        cnt_s3_reg  <= cnt_s2_reg;
        busy_s3_reg <= busy_s2_reg;
    end

    // stage 4: signed numerators of the three divisions
    logic signed [40:0] dacc_s4_reg, ddec_s4_reg;
    logic signed [50:0] dac2_s4_reg;
    logic [DW-1:0]      den2_s4_reg, den4_s4_reg;
    logic [RW-1:0]      ir_s4_reg, fr_s4_reg;
    logic [CW-1:0]      cnt_s4_reg;
    logic               az_s4_reg;
    logic               busy_s4_reg;

    always_ff @(posedge clk)
    begin
        dacc_s4_reg <= {1'b0, n2_s3_reg} - {1'b0, i2_s3_reg};
        ddec_s4_reg <= {1'b0, n2_s3_reg} - {1'b0, f2_s3_reg};
        dac2_s4_reg <= {2'b00, tac_s3_reg} - {11'd0, i2_s3_reg} + {11'd0, f2_s3_reg};
        den2_s4_reg <= {1'b0, a_s3_reg, 1'b0};
        den4_s4_reg <= {a_s3_reg, 2'b00};
        ir_s4_reg   <= ir_s3_reg;
        fr_s4_reg   <= fr_s3_reg;
        cnt_s4_reg  <= cnt_s3_reg;
        az_s4_reg   <= (a_s3_reg == '0);
        busy_s4_reg <= busy_s3_reg;
    end

    // stage 5: magnitudes, biased by den-1 where the signed result rounds up
    logic [NW-1:0] macc, mdec, mac2;

    always_comb
    begin
        macc = dacc_s4_reg[40] ? {11'd0, -dacc_s4_reg} : {11'd0, dacc_s4_reg};
        mdec = ddec_s4_reg[40] ? {11'd0, -ddec_s4_reg} : {11'd0, ddec_s4_reg};
        mac2 = dac2_s4_reg[50] ? {1'b0, -dac2_s4_reg} : {1'b0, dac2_s4_reg};
    end

    logic [NW-1:0]   nacc_s5_reg, ndec_s5_reg, nac2_s5_reg;
    logic [DW-1:0]   den2_s5_reg, den4_s5_reg;
    tpc_pkg::side_t  side_s5_reg;

    always_ff @(posedge clk)
    begin
        // ceiling of a positive value, floor of a negative value round up in magnitude
        nacc_s5_reg <= macc + (dacc_s4_reg[40] ? '0 : {26'd0, den2_s4_reg - 26'd1});
        ndec_s5_reg <= mdec + (ddec_s4_reg[40] ? {26'd0, den2_s4_reg - 26'd1} : '0);
        nac2_s5_reg <= mac2 + (dac2_s4_reg[50] ? '0 : {26'd0, den4_s4_reg - 26'd1});
        den2_s5_reg <= den2_s4_reg;
        den4_s5_reg <= den4_s4_reg;
        side_s5_reg.neg_acc <= dacc_s4_reg[40];
        side_s5_reg.neg_dec <= ddec_s4_reg[40];
        side_s5_reg.neg_ac2 <= dac2_s4_reg[50];
        side_s5_reg.a_zero  <= az_s4_reg;
        side_s5_reg.count   <= cnt_s4_reg;
        side_s5_reg.ir      <= ir_s4_reg;
        side_s5_reg.fr      <= fr_s4_reg;
        side_s5_reg.busy    <= busy_s4_reg;
    end

    // dividers, all of equal depth so results line up
    logic [NW-1:0] qacc, qdec, qac2;

    tpc_div #(.NUM_W(NW), .DEN_W(DW)) u_div_acc (
        .clk   (clk),
        .numer (nacc_s5_reg),
        .denom (den2_s5_reg),
        .quot  (qacc)
    );

    tpc_div #(.NUM_W(NW), .DEN_W(DW)) u_div_dec (
        .clk   (clk),
        .numer (ndec_s5_reg),
        .denom (den2_s5_reg),
        .quot  (qdec)
    );

    tpc_div #(.NUM_W(NW), .DEN_W(DW)) u_div_ac2 (
        .clk   (clk),
        .numer (nac2_s5_reg),
        .denom (den4_s5_reg),
        .quot  (qac2)
    );

    // sideband shift line matching the divider depth
    tpc_pkg::side_t side_reg [NW];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_s5_reg;
        for (int k = 1; k < NW; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    tpc_pkg::side_t sd;
    assign sd = side_reg[NW-1];

    // back stage 1: apply signs, plateau, overlap clamp
    logic signed [WW-1:0] acc, dec, ac2, plat, cnt_w;

    always_comb
    begin
        cnt_w = {30'd0, sd.count};
        acc   = sd.neg_acc ? -{2'b00, qacc} : {2'b00, qacc};
        dec   = sd.neg_dec ? -{2'b00, qdec} : {2'b00, qdec};
        ac2   = sd.neg_ac2 ? -{2'b00, qac2} : {2'b00, qac2};
        if (sd.a_zero)
        begin
            acc = '0;
            dec = '0;
        end
        plat = cnt_w - acc - dec;
    end

    logic signed [WW-1:0] acc_b1_reg, rest_b1_reg;
    logic [CW-1:0]        ac2c_b1_reg;
    logic                 ovl_b1_reg;
    logic [RW-1:0]        ir_b1_reg, fr_b1_reg;
    logic                 busy_b1_reg;

    always_ff @(posedge clk)
    begin
        acc_b1_reg  <= acc;
        rest_b1_reg <= cnt_w - dec;
        priority if (ac2[WW-1])
        begin
            ac2c_b1_reg <= '0;
        end
        else if (ac2 > cnt_w)
        begin
            ac2c_b1_reg <= sd.count;
        end
        else
        begin
            ac2c_b1_reg <= ac2[CW-1:0];
        end
        ovl_b1_reg  <= plat[WW-1];
        ir_b1_reg   <= sd.ir;
        fr_b1_reg   <= sd.fr;
        busy_b1_reg <= sd.busy;
    end

    // back stage 2: select and saturate into the output registers
    logic signed [tpc_pkg::OUT_W-1:0] au_reg, da_reg;
    logic [RW-1:0]                    sr_reg, er_reg;
    logic                             ap_reg, ovl_reg;

    always_ff @(posedge clk)
    begin
        if (ovl_b1_reg)
        begin
            // ramps meet, no cruise plateau
            au_reg <= {8'd0, ac2c_b1_reg};
            da_reg <= {8'd0, ac2c_b1_reg};
        end
        else
        begin
            au_reg <= tpc_pkg::sat32(acc_b1_reg);
            da_reg <= tpc_pkg::sat32(rest_b1_reg);
        end
        sr_reg  <= ir_b1_reg;
        er_reg  <= fr_b1_reg;
        ap_reg  <= !busy_b1_reg;
        ovl_reg <= ovl_b1_reg;
    end

    assign done        = bv_reg[1];
    assign accel_until = au_reg;
    assign decel_after = da_reg;
    assign start_rate  = sr_reg;
    assign end_rate    = er_reg;
    assign applied     = ap_reg;

    // checks
    `TPC_ASSERT_DLY(a_latency, accept, LAT, done, "result strobe missing after fixed latency")
    `TPC_ASSERT_IMP(a_order, done, accel_until <= decel_after, "accel end after decel start")
    `TPC_ASSERT_IMP(a_overlap, done && ovl_reg, accel_until == decel_after,
                    "overlapping ramps must meet at one step")

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the trapezoid profile calculator
module tb_top;

    localparam int RATE_W   = tpc_pkg::RATE_W;
    localparam int FACTOR_W = tpc_pkg::FACTOR_W;
    localparam int ACCEL_W  = tpc_pkg::ACCEL_W;
    localparam int COUNT_W  = tpc_pkg::COUNT_W;
    localparam int MINR_W   = tpc_pkg::MINR_W;
    localparam int OUT_W    = tpc_pkg::OUT_W;
    localparam logic [RATE_W-1:0] RATE_MAX       = tpc_pkg::RATE_MAX;
    localparam logic [MINR_W-1:0] MIN_RATE_RESET = tpc_pkg::MIN_RATE_RESET;

    // one segment as driven on the input ports
    typedef struct packed {
        logic [RATE_W-1:0]   nominal;
        logic [FACTOR_W-1:0] efac;
        logic [FACTOR_W-1:0] xfac;
        logic [ACCEL_W-1:0]  accel;
        logic [COUNT_W-1:0]  count;
        logic                busy_in;
    } segment_t;

    // one profile as seen on the result ports
    typedef struct packed {
        logic signed [OUT_W-1:0] acc_until;
        logic signed [OUT_W-1:0] dec_after;
        logic [RATE_W-1:0]       srate;
        logic [RATE_W-1:0]       erate;
        logic                    appl;
    } profile_t;

    localparam int LATENCY = 59;
    localparam longint CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [RATE_W-1:0]   cruise_rate;
    logic [FACTOR_W-1:0] entry_scale;
    logic [FACTOR_W-1:0] exit_scale;
    logic [ACCEL_W-1:0]  accel_rate;
    logic [COUNT_W-1:0]  step_count;
    logic                busy_req;
    logic                cfg_we;
    logic [MINR_W-1:0]   cfg_wdata;
    logic                done;
    logic signed [OUT_W-1:0] accel_until;
    logic signed [OUT_W-1:0] decel_after;
    logic [RATE_W-1:0]   start_rate;
    logic [RATE_W-1:0]   end_rate;
    logic                applied;

    segment_t segment_q[$];   // segments waiting for the driver
    profile_t profile_q[$];   // profiles predicted, oldest first
    logic [MINR_W-1:0] min_rate;  // predictor copy of the register
    int idle_pct;
    int errors;
    int profiles_seen;
    longint cycles;

    trapezoid_profile_calc u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cruise_rate  (cruise_rate),
        .entry_scale  (entry_scale),
        .exit_scale   (exit_scale),
        .accel_rate   (accel_rate),
        .step_count   (step_count),
        .busy_req     (busy_req),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .accel_until  (accel_until),
        .decel_after  (decel_after),
        .start_rate   (start_rate),
        .end_rate     (end_rate),
        .applied      (applied)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // cycle counter doubles as the watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ceiling of rate times factor, saturated, then raised to the minimum
    function automatic longint scaled_rate(input longint nom, input longint fac);
        longint r;
        r = (nom * fac + 65535) >>> 16;
        if (r > longint'(RATE_MAX))
        begin
            r = RATE_MAX;
        end
        if (r < longint'(min_rate))
        begin
            r = min_rate;
        end
        return r;
    endfunction

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
        begin
            q--;
        end
        return q;
    endfunction

    function automatic longint ceil_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n > 0)
        begin
            q++;
        end
        return q;
    endfunction

    function automatic logic signed [OUT_W-1:0] clip32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[OUT_W-1:0];
    endfunction

    // expected profile of one segment under the current minimum rate
    function automatic profile_t plan_profile(input segment_t s);
        profile_t p;
        longint ir;
        longint fr;
        longint n2;
        longint i2;
        longint f2;
        longint a;
        longint c;
        longint acc;
        longint dec;
        longint plat;
        ir = scaled_rate(s.nominal, s.efac);
        fr = scaled_rate(s.nominal, s.xfac);
        n2 = longint'(s.nominal) * longint'(s.nominal);
        i2 = ir * ir;
        f2 = fr * fr;
        a = s.accel;
        c = s.count;
        acc = 0;
        dec = 0;
        if (a != 0)
        begin
            acc = ceil_div(n2 - i2, 2 * a);
            dec = floor_div(n2 - f2, 2 * a);
        end
        plat = c - acc - dec;
        // ramps overlap: accelerate up to where the two ramps meet
        if (plat < 0)
        begin
            acc = ceil_div(2 * a * c - i2 + f2, 4 * a);
            if (acc < 0)
            begin
                acc = 0;
            end
            if (acc > c)
            begin
                acc = c;
            end
            plat = 0;
        end
        p.acc_until = clip32(acc);
        p.dec_after = clip32(acc + plat);
        p.srate = ir[RATE_W-1:0];
        p.erate = fr[RATE_W-1:0];
        p.appl = ~s.busy_in;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s on profile %0d: got %0d, want %0d", what, profiles_seen, got,
                 want);
        errors++;
    endtask

    // driver: one segment per transfer, gaps at the current idle percentage
    always @(negedge clk)
    begin
        if (rst_n && segment_q.size() > 0 && ($urandom_range(99) >= idle_pct))
        begin
            if (!(start && busy))
            begin
                start        <= 1'b1;
                cruise_rate  <= segment_q[0].nominal;
                entry_scale  <= segment_q[0].efac;
                exit_scale   <= segment_q[0].xfac;
                accel_rate   <= segment_q[0].accel;
                step_count   <= segment_q[0].count;
                busy_req     <= segment_q[0].busy_in;
            end
        end
        else if (!(start && busy))
        begin
            start <= 1'b0;
        end
    end

    // accepted start transfer: predict and drop it from the queue
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            profile_q.push_back(plan_profile(segment_q[0]));
            void'(segment_q.pop_front());
        end
    end

    // monitor: every done strobe is checked against the oldest prediction
    always @(posedge clk)
    begin
        profile_t want;
        if (rst_n && done)
        begin
            if (profile_q.size() == 0)
            begin
                report_mismatch("unexpected profile", 1, 0);
            end
            else
            begin
                want = profile_q.pop_front();
                if (accel_until !== want.acc_until)
                    report_mismatch("accel_until", accel_until, want.acc_until);
                if (decel_after !== want.dec_after)
                    report_mismatch("decel_after", decel_after, want.dec_after);
                if (start_rate !== want.srate)
                    report_mismatch("start_rate", start_rate, want.srate);
                if (end_rate !== want.erate)
                    report_mismatch("end_rate", end_rate, want.erate);
                if (applied !== want.appl)
                    report_mismatch("applied", applied, want.appl);
            end
            profiles_seen++;
        end
    end

    // random segment, mostly realistic with ramps that often overlap
    function automatic segment_t random_segment();
        segment_t s;
        int k;
        k = int'($urandom_range(9));
        s.nominal = (k < 3) ? RATE_W'($urandom_range(5000)) : RATE_W'($urandom);
        s.efac = ($urandom_range(7) == 0) ? 17'd65536 : FACTOR_W'($urandom_range(131071));
        s.xfac = ($urandom_range(7) == 0) ? 17'd65536 : FACTOR_W'($urandom_range(131071));
        if ($urandom_range(3) == 0)
        begin
            s.efac = FACTOR_W'($urandom_range(65536));
            s.xfac = FACTOR_W'($urandom_range(65536));
        end
        s.accel = (k == 0) ? 24'd0 :
                  ((k < 5) ? ACCEL_W'($urandom_range(100000)) : ACCEL_W'($urandom));
        s.count = (k < 6) ? COUNT_W'($urandom_range(20000)) : COUNT_W'($urandom);
        s.busy_in = 1'($urandom_range(1));
        return s;
    endfunction

    function automatic segment_t make_segment(input longint n, input longint e, input longint x,
                                              input longint a, input longint c,
                                              input logic b);
        segment_t s;
        s.nominal = RATE_W'(n);
        s.efac = FACTOR_W'(e);
        s.xfac = FACTOR_W'(x);
        s.accel = ACCEL_W'(a);
        s.count = COUNT_W'(c);
        s.busy_in = b;
        return s;
    endfunction

    // stop feeding until the pipeline has drained, then settle
    task automatic wait_drained();
        while (segment_q.size() > 0 || profile_q.size() > 0 || start)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_min_rate(input logic [MINR_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        min_rate = v;
    endtask

    initial
    begin
        int phase;
        logic [MINR_W-1:0] min_settings[5];
        rst_n = 1'b0;
        start = 1'b0;
        cruise_rate = '0;
        entry_scale = '0;
        exit_scale = '0;
        accel_rate = '0;
        step_count = '0;
        busy_req = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        errors = 0;
        profiles_seen = 0;
        cycles = 0;
        idle_pct = 0;
        min_rate = MIN_RATE_RESET;
        min_settings = '{16'd0, 16'd65535, 16'd1, 16'd5000, 16'd120};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, zero accel, overlapping ramps, saturation, busy
        segment_q.push_back(make_segment(0, 0, 0, 0, 0, 0));
        segment_q.push_back(make_segment(1048575, 65536, 65536, 16777215, 16777215, 0));
        segment_q.push_back(make_segment(1048575, 131071, 131071, 1, 16777215, 1));
        segment_q.push_back(make_segment(1048575, 0, 0, 1, 16777215, 0));
        segment_q.push_back(make_segment(1048575, 0, 0, 1, 0, 0));
        segment_q.push_back(make_segment(10000, 32768, 16384, 0, 500, 1));
        segment_q.push_back(make_segment(10000, 0, 0, 1000, 10, 0));
        segment_q.push_back(make_segment(10000, 6554, 65536, 1000, 100000, 0));
        segment_q.push_back(make_segment(50, 65536, 65536, 300, 40, 0));
        segment_q.push_back(make_segment(4000, 131071, 0, 500, 3, 0));
        segment_q.push_back(make_segment(4000, 0, 131071, 500, 3, 1));
        segment_q.push_back(make_segment(1048575, 1, 1, 16777215, 1, 0));
        segment_q.push_back(make_segment(2000, 65535, 65535, 16777215, 16777215, 1));
        segment_q.push_back(make_segment(700000, 131071, 0, 3, 16777215, 0));
        wait_drained();

        // random phases, each under another minimum rate, some with idle gaps
        for (phase = 0; phase < 5; phase++)
        begin
            write_min_rate(min_settings[phase]);
            idle_pct = (phase == 1) ? 87 : ((phase == 3) ? 28 : 0);
            repeat (270)
            begin
                segment_q.push_back(random_segment());
            end
            wait_drained();
        end

        $display("covered %0d profiles over five minimum-rate settings incl. 0 and 65535",
                 profiles_seen);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== trapezoid_profile_calc.f =====
+incdir+rtl
rtl/tpc_pkg.sv
rtl/tpc_div.sv
rtl/trapezoid_profile_calc.sv
tb/sv/tb_top.sv
